[sv/poslst_pkg.sv]
// Package for the positional list engine: field widths, opcode, status and
// operation-kind codes, and the command and status bundles between the
// controller and the datapath. No dependencies.
`default_nettype none

package poslst_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned CAPACITY_DEF   = 32;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Fixed field widths of the stream payloads.
  localparam int unsigned OPCODE_W   = 3;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned POSITION_W = 6;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_W    = 6;
  localparam int unsigned RDATA_W    = 32;

  localparam int unsigned IN_FIELDS_W  = OPCODE_W + VALUE_W + POSITION_W;
  localparam int unsigned OUT_FIELDS_W = STATUS_W + COUNT_W + RDATA_W;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INS_FIRST = 3'd0,
    OP_INS_LAST  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FIRST = 3'd3,
    OP_DEL_LAST  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_READ_AT   = 3'd6
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_POS = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_INS  = 2'd1,
    KIND_DEL  = 2'd2,
    KIND_READ = 2'd3
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic walk_start;
    logic walk_step;
    logic link_new;
    logic link_prev;
    logic unlink;
    logic elem_read;
    logic load_result;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_e kind;
    logic  stat_ok;
    logic  tgt_one;
    logic  walk_last;
    logic  out_free;
  } stat_t;

endpackage

`default_nettype wire

[sv/poslst_dp.sv]
// Datapath of the positional list engine: element and link memories, head,
// free map, count, walk registers and the result register.
// Depends on poslst_pkg.
`default_nettype none

module poslst_dp
  import poslst_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [OPCODE_W-1:0]          opcode_i,
  input  wire logic signed [VALUE_W-1:0]    value_i,
  input  wire logic [POSITION_W-1:0]        position_i,
  input  wire cmd_t                         cmd_i,
  output      stat_t                        stat_o,
  input  wire logic                         m_tready_i,
  output      logic                         m_tvalid_o,
  output      logic [STATUS_W-1:0]          status_o,
  output      logic [COUNT_W-1:0]           count_o,
  output      logic signed [RDATA_W-1:0]    read_value_o
);

  localparam int unsigned SLOT_W = $clog2(CAPACITY);
  localparam int unsigned CW     = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W  = ((CW > POSITION_W) ? CW : POSITION_W) + 1;
  localparam int unsigned GROUPS = (CAPACITY + 7) / 8;

  // Memories.
  logic [DATA_WIDTH-1:0] elem_mem [CAPACITY];
  logic [SLOT_W-1:0]     link_mem [CAPACITY];

  // Control state.
  logic [SLOT_W-1:0]   head_q;
  logic [CAPACITY-1:0] free_map_q;
  logic [CW-1:0]       count_q;
  logic [CW-1:0]       walk_cnt_q;
  logic                walk_first_q;
  logic                out_valid_q;

  // Captured item.
  kind_e               kind_q,  kind_d;
  status_e             stat_q,  stat_d;
  logic [CW-1:0]       tgt_q;
  logic                tgt_one_q;
  logic [DATA_WIDTH-1:0] value_q;
  logic [SLOT_W-1:0]   alloc_q;

  // Walk registers.
  logic [SLOT_W-1:0]   cur_q;
  logic [SLOT_W-1:0]   prev_q;
  logic [SLOT_W-1:0]   link_rd_q;
  logic [SLOT_W-1:0]   link_raddr;
  logic [DATA_WIDTH-1:0] elem_rd_q;

  // Result register payload.
  logic [STATUS_W-1:0] out_status_q;
  logic [COUNT_W-1:0]  out_count_q;
  logic [RDATA_W-1:0]  out_rdata_q;

  logic [CMP_W-1:0]    pos_x, cnt_x, cnt_p1, tgt_x;
  logic [GROUPS*8-1:0] free_pad;
  logic [SLOT_W-1:0]   free_slot;
  logic                lw_en;
  logic [SLOT_W-1:0]   lw_addr;
  logic [SLOT_W-1:0]   lw_data;

  // Decode and range checks on the incoming item.
  assign pos_x  = CMP_W'(position_i);
  assign cnt_x  = CMP_W'(count_q);
  assign cnt_p1 = cnt_x + CMP_W'(1);

  always_comb begin
    kind_d = KIND_NONE;
    stat_d = STAT_OK;
    tgt_x  = pos_x;
    unique case (opcode_i)
      OP_INS_FIRST: begin
        kind_d = KIND_INS;
        tgt_x  = CMP_W'(1);
      end
      OP_INS_LAST: begin
        kind_d = KIND_INS;
        tgt_x  = cnt_p1;
      end
      OP_INS_AT: begin
        kind_d = KIND_INS;
        if (pos_x == '0 || pos_x > cnt_p1) begin
          stat_d = STAT_BAD_POS;
        end
      end
      OP_DEL_FIRST: begin
        kind_d = KIND_DEL;
        tgt_x  = CMP_W'(1);
        if (cnt_x == '0) begin
          stat_d = STAT_EMPTY;
        end
      end
      OP_DEL_LAST: begin
        kind_d = KIND_DEL;
        tgt_x  = cnt_x;
        if (cnt_x == '0) begin
          stat_d = STAT_EMPTY;
        end
      end
      OP_DEL_AT, OP_READ_AT: begin
        kind_d = (opcode_i == OP_READ_AT) ? KIND_READ : KIND_DEL;
        if (pos_x == '0 || pos_x > cnt_x) begin
          stat_d = STAT_BAD_POS;
        end
      end
      default: begin
        kind_d = KIND_NONE;
      end
    endcase
    if (kind_d == KIND_INS && stat_d == STAT_OK && cnt_x >= CMP_W'(CAPACITY)) begin
      stat_d = STAT_FULL;
    end
  end

  // Lowest free slot: a priority pick inside each group of eight, then
  // across the groups.
  assign free_pad = (GROUPS*8)'(free_map_q);

  always_comb begin : find_free
    int         slot_v;
    logic [2:0] idx_v;
    logic       any_v;
    slot_v = 0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      any_v = 1'b0;
      idx_v = 3'd0;
      for (int i = 7; i >= 0; i--) begin
        if (free_pad[g*8+i]) begin
          any_v = 1'b1;
          idx_v = 3'(i);
        end
      end
      if (any_v) begin
        slot_v = g * 8 + int'(idx_v);
      end
    end
    free_slot = SLOT_W'(slot_v);
  end

  // Captured item registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q    <= kind_d;
      stat_q    <= stat_d;
      tgt_q     <= CW'(tgt_x);
      tgt_one_q <= (tgt_x == CMP_W'(1));
      value_q   <= DATA_WIDTH'(value_i);
      alloc_q   <= free_slot;
    end
  end

  // List walk: each step reads the link of the slot it reaches.
  assign link_raddr = walk_first_q ? head_q : link_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_step) begin
      link_rd_q <= link_mem[link_raddr];
      cur_q     <= link_raddr;
      prev_q    <= cur_q;
    end
  end

  // Link memory write port.
  always_comb begin
    lw_en   = 1'b0;
    lw_addr = alloc_q;
    lw_data = link_rd_q;
    if (cmd_i.link_new) begin
      lw_en   = 1'b1;
      lw_addr = alloc_q;
      lw_data = tgt_one_q ? head_q : link_rd_q;
    end else if (cmd_i.link_prev) begin
      lw_en   = 1'b1;
      lw_addr = cur_q;
      lw_data = alloc_q;
    end else if (cmd_i.unlink && !tgt_one_q) begin
      lw_en   = 1'b1;
      lw_addr = prev_q;
      lw_data = link_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lw_en) begin
      link_mem[lw_addr] <= lw_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.link_new) begin
      elem_mem[alloc_q] <= value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.elem_read) begin
      elem_rd_q <= elem_mem[cur_q];
    end
  end

  // List state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      free_map_q   <= '1;
      count_q      <= '0;
      walk_cnt_q   <= '0;
      walk_first_q <= 1'b0;
    end else begin
      if (cmd_i.walk_start) begin
        walk_cnt_q   <= (kind_q == KIND_INS) ? tgt_q - CW'(1) : tgt_q;
        walk_first_q <= 1'b1;
      end else if (cmd_i.walk_step) begin
        walk_cnt_q   <= walk_cnt_q - CW'(1);
        walk_first_q <= 1'b0;
      end
      if (cmd_i.link_new) begin
        free_map_q[alloc_q] <= 1'b0;
        count_q             <= count_q + CW'(1);
        if (tgt_one_q) begin
          head_q <= alloc_q;
        end
      end else if (cmd_i.unlink) begin
        free_map_q[cur_q] <= 1'b1;
        count_q           <= count_q - CW'(1);
        if (tgt_one_q) begin
          head_q <= link_rd_q;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_result) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      out_status_q <= stat_q;
      out_count_q  <= COUNT_W'(count_q);
      out_rdata_q  <= (kind_q == KIND_READ && stat_q == STAT_OK)
                      ? RDATA_W'(signed'(elem_rd_q)) : '0;
    end
  end

  assign m_tvalid_o   = out_valid_q;
  assign status_o     = out_status_q;
  assign count_o      = out_count_q;
  assign read_value_o = out_rdata_q;

  assign stat_o.kind      = kind_q;
  assign stat_o.stat_ok   = (stat_q == STAT_OK);
  assign stat_o.tgt_one   = tgt_one_q;
  assign stat_o.walk_last = (walk_cnt_q == CW'(1));
  assign stat_o.out_free  = !out_valid_q || m_tready_i;

  // Every slot is either free or holds an element of the list.
  a_free_tally: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(free_map_q) + int'(count_q) == CAPACITY)
    else $error("free map and element count disagree");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("element count beyond capacity");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.link_new |=> count_q == $past(count_q) + CW'(1))
    else $error("insert did not raise the element count");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_result |-> (!out_valid_q || m_tready_i))
    else $error("result overwritten before its transfer");

endmodule

`default_nettype wire

[sv/poslst_ctrl.sv]
// Controller of the positional list engine: one-hot state machine that
// sequences capture, list walk, relinking, reads and the result.
// Depends on poslst_pkg.
`default_nettype none

module poslst_ctrl
  import poslst_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  s_tvalid_i,
  output      logic  s_tready_o,
  input  wire stat_t stat_i,
  output      cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_CHECK     = 8'b0000_0010,
    S_WALK      = 8'b0000_0100,
    S_LINK_NEW  = 8'b0000_1000,
    S_LINK_PREV = 8'b0001_0000,
    S_UNLINK    = 8'b0010_0000,
    S_READ      = 8'b0100_0000,
    S_RESP      = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  assign s_tready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat_i.stat_ok || stat_i.kind == KIND_NONE) begin
          state_d = S_RESP;
        end else if (stat_i.kind == KIND_INS && stat_i.tgt_one) begin
          state_d = S_LINK_NEW;
        end else begin
          cmd_o.walk_start = 1'b1;
          state_d          = S_WALK;
        end
      end
      S_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (stat_i.walk_last) begin
          unique case (stat_i.kind)
            KIND_INS: state_d = S_LINK_NEW;
            KIND_DEL: state_d = S_UNLINK;
            default:  state_d = S_READ;
          endcase
        end
      end
      S_LINK_NEW: begin
        cmd_o.link_new = 1'b1;
        state_d        = stat_i.tgt_one ? S_RESP : S_LINK_PREV;
      end
      S_LINK_PREV: begin
        cmd_o.link_prev = 1'b1;
        state_d         = S_RESP;
      end
      S_UNLINK: begin
        cmd_o.unlink = 1'b1;
        state_d      = S_RESP;
      end
      S_READ: begin
        cmd_o.elem_read = 1'b1;
        state_d         = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.load_result = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[sv/positional_list_engine.sv]
// Positional list engine, top level. An item is taken only in the idle state, one at a time.
// Failed or unused operations go straight to the result, an insert at the front skips the
// list walk, and a read, delete or insert (p>1) at position p first walks the list to p.
// The walk through the link memory follows one link per cycle; a new item is taken only once
// the last result is loaded. Reset (rst_ni low, asynchronous) empties the list.
// Depends on poslst_pkg, poslst_ctrl and poslst_dp.
`default_nettype none

module positional_list_engine
  import poslst_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Input stream.
  input  wire logic                   s_axis_tvalid_i,
  output      logic                   s_axis_tready_o,
  // Fields from bit 0 up: opcode [2:0], value [34:3], position [40:35], zero padding.
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // Result stream.
  output      logic                   m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // Fields from bit 0 up: status [1:0], element_count [7:2], read_value [39:8].
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  // The controller and the datapath talk only through these two bundles.
  cmd_t  cmd;
  stat_t stat;

  logic [OPCODE_W-1:0]        opcode;
  logic signed [VALUE_W-1:0]  value;
  logic [POSITION_W-1:0]      position;
  logic [STATUS_W-1:0]        status;
  logic [COUNT_W-1:0]         element_count;
  logic signed [RDATA_W-1:0]  read_value;

  // Unpack the input transfer.
  assign opcode   = s_axis_tdata_i[OPCODE_W-1:0];
  assign value    = s_axis_tdata_i[OPCODE_W +: VALUE_W];
  assign position = s_axis_tdata_i[OPCODE_W + VALUE_W +: POSITION_W];

  // The state machine: capture, walk, relink or read, then hand over the result.
  poslst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The datapath holds the list in two memories and owns the result register, so a finished
  // result may wait for its transfer while the controller returns to idle.
  poslst_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .opcode_i     (opcode),
    .value_i      (value),
    .position_i   (position),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .m_tready_i   (m_axis_tready_i),
    .m_tvalid_o   (m_axis_tvalid_o),
    .status_o     (status),
    .count_o      (element_count),
    .read_value_o (read_value)
  );

  // Pack the result transfer; the payload is exactly five bytes.
  assign m_axis_tdata_o = OUT_TDATA_W'({read_value, element_count, status});

endmodule

`default_nettype wire
